// ===== src/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Operation and status codes, request/result payloads and the cell control.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int WORD_W = 32;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -1;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [WORD_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
        status_t                  status;
    } rsp_t;

    // One command broadcast to every cell of the chain
    typedef struct packed {
        logic                     shift_right;
        logic                     shift_left;
        logic                     push_rear;
        logic                     pop_rear;
        logic signed [WORD_W-1:0] push_word;
    } cdq_ctrl_t;

endpackage

// ===== src/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque chain
// Holds one word and its occupied bit; shifts with its neighbors, loads at
// the rear boundary and reports its word when it is the last occupied cell.
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdq_pkg::cdq_ctrl_t                ctrl,
    input  logic                              left_valid,
    input  logic signed [cdq_pkg::WORD_W-1:0] left_word,
    input  logic                              right_valid,
    input  logic signed [cdq_pkg::WORD_W-1:0] right_word,
    output logic                              valid,
    output logic signed [cdq_pkg::WORD_W-1:0] word,
    output logic signed [cdq_pkg::WORD_W-1:0] rear_word
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [cdq_pkg::WORD_W-1:0] word_reg;
    logic signed [cdq_pkg::WORD_W-1:0] word_next;
    logic                              is_last;

    assign is_last = valid_reg && !right_valid;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (ctrl.shift_right)
        begin
            valid_next = left_valid;
            word_next  = left_word;
        end
        else if (ctrl.shift_left)
        begin
            valid_next = right_valid;
            word_next  = right_word;
        end
        else if (ctrl.push_rear && !valid_reg && left_valid)
        begin
            // first free cell takes the new rear word
            valid_next = 1'b1;
            word_next  = ctrl.push_word;
        end
        else if (ctrl.pop_rear && is_last)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign valid     = valid_reg;
    assign word      = word_reg;
    assign rear_word = is_last ? word_reg : '0;

endmodule

// ===== src/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of signed words
// A chain of cells keeps the words in order, front in the first cell.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request (operation, data_value); it is taken at the
//   rising edge where start is high and busy is low. Operations: push front,
//   push rear, pop front, pop rear.
//   The chain updates at that edge. At the next edge the result register
//   samples front, rear, empty and full from the settled cells, and done is
//   high for exactly one cycle with the result on the result port. The
//   result is taken at the edge that ends that cycle; there is no stall.
//   busy is high for the cycle in which the result register samples the
//   chain, so no new request is taken until that sample is done.
//   A push when full or a pop when empty leaves the contents unchanged and
//   is flagged in status. front_value and rear_value read -1 when empty.
//   Reset (rst_n low, asynchronous) empties the deque at once; no sweep.
// ----------------------------------------------------------------------------
module circular_deque (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cdq_pkg::req_t request,
    output logic          done,
    output cdq_pkg::rsp_t result
);

    localparam int N = cdq_pkg::DEPTH;

    logic                              link_valid [0:N+1];
    logic signed [cdq_pkg::WORD_W-1:0] link_word  [0:N+1];
    logic signed [cdq_pkg::WORD_W-1:0] cell_rear  [0:N-1];
    logic        [N-1:0]               valid_vec;
    logic        [N-1:0]               valid_inc;

    cdq_pkg::cdq_ctrl_t                ctrl;
    logic                              accept;
    logic                              is_full;
    logic                              is_empty;
    logic signed [cdq_pkg::WORD_W-1:0] rear_any;
    logic signed [cdq_pkg::WORD_W-1:0] popped;
    cdq_pkg::status_t                  status;

    logic                              pend_reg;
    logic signed [cdq_pkg::WORD_W-1:0] popped_reg;
    cdq_pkg::status_t                  status_reg;
    logic                              done_reg;
    cdq_pkg::rsp_t                     result_reg;
    cdq_pkg::rsp_t                     result_next;

    assign link_valid[0]   = 1'b1;
    assign link_word[0]    = request.data_value;
    assign link_valid[N+1] = 1'b0;
    assign link_word[N+1]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            cdq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_valid  (link_valid[gi]),
                .left_word   (link_word[gi]),
                .right_valid (link_valid[gi+2]),
                .right_word  (link_word[gi+2]),
                .valid       (link_valid[gi+1]),
                .word        (link_word[gi+1]),
                .rear_word   (cell_rear[gi])
            );
            assign valid_vec[gi] = link_valid[gi+1];
        end
    endgenerate

    assign is_full  = link_valid[N];
    assign is_empty = !link_valid[1];
    assign accept   = start && !busy;

    // only the last occupied cell drives a nonzero rear word
    always_comb
    begin
        rear_any = '0;
        for (int i = 0; i < N; i++)
        begin
            rear_any = rear_any | cell_rear[i];
        end
    end

    always_comb
    begin
        ctrl.shift_right = 1'b0;
        ctrl.shift_left  = 1'b0;
        ctrl.push_rear   = 1'b0;
        ctrl.pop_rear    = 1'b0;
        ctrl.push_word   = request.data_value;
        popped           = '0;
        status           = cdq_pkg::ST_DONE;
        case (request.operation)
            cdq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                    status = cdq_pkg::ST_FULL;
                else
                    ctrl.shift_right = accept;
            end
            cdq_pkg::OP_PUSH_REAR:
            begin
                if (is_full)
                    status = cdq_pkg::ST_FULL;
                else
                    ctrl.push_rear = accept;
            end
            cdq_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                    status = cdq_pkg::ST_EMPTY;
                else
                begin
                    ctrl.shift_left = accept;
                    popped          = link_word[1];
                end
            end
            cdq_pkg::OP_POP_REAR:
            begin
                if (is_empty)
                    status = cdq_pkg::ST_EMPTY;
                else
                begin
                    ctrl.pop_rear = accept;
                    popped        = rear_any;
                end
            end
            default:
            begin
                status = cdq_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        result_next.popped_value = popped_reg;
        result_next.front_value  = is_empty ? cdq_pkg::EMPTY_WORD : link_word[1];
        result_next.rear_value   = is_empty ? cdq_pkg::EMPTY_WORD : rear_any;
        result_next.is_empty     = is_empty;
        result_next.is_full      = is_full;
        result_next.status       = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= accept;
            done_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped;
            status_reg <= status;
        end
        if (pend_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = pend_reg;
    assign done   = done_reg;
    assign result = result_reg;

    assign valid_inc = valid_vec + N'(1);

    // occupied cells always form an unbroken run from the front
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_inc & valid_vec) == '0)
        else $error("occupied cells are not contiguous");

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.is_full && result.is_empty))
        else $error("result flags full and empty together");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result strobe missing after request");

    a_refused_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == cdq_pkg::ST_EMPTY) |->
        (result.is_empty && result.popped_value == '0))
        else $error("refused pop on a non-empty deque");

endmodule
